>>> rtl/gnp_pkg.sv
// ----------------------------------------------------------------------------
// gnp_pkg: shared types, constants and tables for the gradient noise pixel
// Fixed-point formats, hash constants, the quarter-wave sine table and the
// grid divider table used by the front and back sections.
// ----------------------------------------------------------------------------
package gnp_pkg;

	// Noise configuration
	localparam int MAX_OCTAVES     = 8;
	localparam int COORD_BITS      = 16;
	localparam int FRAC_BITS       = 16;
	localparam int SINE_TABLE_BITS = 10;

	// Port widths
	localparam int PIXEL_W = 16;
	localparam int CFG_W   = 4;
	localparam int GREY_W  = 8;
	localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
	localparam logic [CFG_W-1:0] OCTAVE_RESET = CFG_W'(4);

	// Grid of 400 split as 25 * 2^4; the odd part uses a reciprocal multiply
	localparam int GRID_ODD    = 25;
	localparam int GRID_POW    = 4;
	localparam int GRID_SHIFT  = FRAC_BITS + MAX_OCTAVES - 1 - GRID_POW;
	localparam int RECIP       = 671089;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 20;
	localparam int DIVP_W      = PIXEL_W + RECIP_W;
	localparam int QUOT_W      = PIXEL_W - 4;
	localparam int REM_W       = 5;
	localparam int COORD_W     = QUOT_W + GRID_SHIFT;
	localparam int UX_W        = COORD_BITS + FRAC_BITS;

	// Corner hash
	localparam logic [31:0] HASH_K1 = 32'd3284157443;
	localparam logic [31:0] HASH_K2 = 32'd1911520717;
	localparam logic [31:0] HASH_K3 = 32'd2048419325;

	// Sine polynomial, Q15
	localparam longint unsigned SIN_C1 = 51472;
	localparam longint unsigned SIN_C3 = 21024;
	localparam longint unsigned SIN_C5 = 2320;
	localparam int QTR_BITS = SINE_TABLE_BITS - 2;
	localparam int QTR_N    = 1 << QTR_BITS;
	localparam logic [SINE_TABLE_BITS-1:0] COS_OFS = SINE_TABLE_BITS'(QTR_N);

	// Datapath widths
	localparam int GRAD_W = 16;
	localparam int DXY_W  = FRAC_BITS + 2;
	localparam int PROD_W = DXY_W + GRAD_W;
	localparam int VAL_W  = 21;
	localparam int BL_W   = VAL_W + 18;
	localparam int SUM_W  = VAL_W + $clog2(MAX_OCTAVES) + 1;
	localparam int SCL_W  = SUM_W + 17;
	localparam logic signed [16:0] SCALE_Q15 = 17'sd39322;
	localparam int Q15_ONE = 32768;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Back section valid stages: eight octave stages, sum, scale
	localparam int OCT_STAGES  = 8;
	localparam int BACK_STAGES = OCT_STAGES + 2;

	typedef logic signed [GRAD_W-1:0] grad_t;
	typedef logic [14:0] qtr_tab_t [QTR_N];
	typedef logic [GRID_SHIFT-1:0] div_tab_t [1 << REM_W];

	// One classified pixel: grid-scaled coordinates at the top octave
	typedef struct packed {
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		logic [OCT_W-1:0]   n;
	} coord_item_t;

	// Quarter-wave sine magnitudes, capped at 32767
	function automatic qtr_tab_t build_qtr();
		qtr_tab_t tab;
		longint unsigned r, r2, t, m;
		for (int k = 0; k < QTR_N; k++) begin
			r  = longint'(k) << (15 - QTR_BITS);
			r2 = (r * r) >> 15;
			t  = SIN_C3 - ((SIN_C5 * r2) >> 15);
			t  = SIN_C1 - ((t * r2) >> 15);
			m  = (t * r) >> 15;
			tab[k] = (m > 32767) ? 15'h7FFF : 15'(m);
		end
		return tab;
	endfunction

	localparam qtr_tab_t QTR_TAB = build_qtr();

	// floor(b * 2^GRID_SHIFT / 25) for each remainder b
	function automatic div_tab_t build_div();
		div_tab_t tab;
		for (int b = 0; b < (1 << REM_W); b++) begin
			tab[b] = GRID_SHIFT'((longint'(b) << GRID_SHIFT) / GRID_ODD);
		end
		return tab;
	endfunction

	localparam div_tab_t DIV_TAB = build_div();

	// Full-circle sine from the top hash bits
	function automatic grad_t grad_sine(input logic [SINE_TABLE_BITS-1:0] h);
		logic [QTR_BITS-1:0] k;
		logic [QTR_BITS-1:0] k_neg;
		logic [14:0]         m;
		k     = h[QTR_BITS-1:0];
		k_neg = ~k + 1'b1;
		if (h[QTR_BITS]) begin
			m = (k == '0) ? 15'h7FFF : QTR_TAB[k_neg];
		end else begin
			m = QTR_TAB[k];
		end
		return h[SINE_TABLE_BITS-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic [31:0] rot_half(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

endpackage

>>> rtl/gnp_front.sv
// ----------------------------------------------------------------------------
// gnp_front: input beat capture and grid scaling
// Holds the octave count register, takes pixel beats and scales both
// coordinates by 2^(FRAC+MAX-1)/400 before handing them to the queue.
// ----------------------------------------------------------------------------
module gnp_front import gnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIXEL_W-1:0] pixel_x,
	input  logic [PIXEL_W-1:0] pixel_y,
	input  logic               cfg_write_en,
	input  logic [CFG_W-1:0]   cfg_write_data,
	input  logic               queue_full,
	output logic               push,
	output coord_item_t        item
);

	logic [CFG_W-1:0]   octave_count_q;
	logic [OCT_W-1:0]   n_eff;
	logic               v_s1, v_s2, v_s3;
	logic               front_en;
	logic [PIXEL_W-1:0] px_s1, py_s1, px_s2, py_s2;
	logic [OCT_W-1:0]   n_s1, n_s2, n_s3;
	logic [QUOT_W-1:0]  ax_s2, ay_s2;
	logic [COORD_W-1:0] qx_s3, qy_s3;
	logic [DIVP_W-1:0]  prod_x, prod_y;
	logic [PIXEL_W-1:0] ax25, ay25, rx, ry;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCTAVE_RESET;
		end else if (cfg_write_en) begin
			octave_count_q <= cfg_write_data;
		end
	end

	// Clamp the octave count
	always_comb begin
		if (32'(octave_count_q) > MAX_OCTAVES) begin
			n_eff = OCT_W'(MAX_OCTAVES);
		end else begin
			n_eff = OCT_W'(octave_count_q);
		end
	end

	// Advance unless the last stage holds a beat the queue cannot take
	assign front_en = !(v_s3 && queue_full);
	assign in_stall = !front_en;
	assign push     = v_s3 && front_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Quotient by 25 through the reciprocal
	assign prod_x = DIVP_W'(px_s1) * DIVP_W'(RECIP);
	assign prod_y = DIVP_W'(py_s1) * DIVP_W'(RECIP);

	// Remainder by 25
	assign ax25 = {ax_s2, 4'b0} + {1'b0, ax_s2, 3'b0} + PIXEL_W'(ax_s2);
	assign ay25 = {ay_s2, 4'b0} + {1'b0, ay_s2, 3'b0} + PIXEL_W'(ay_s2);
	assign rx   = px_s2 - ax25;
	assign ry   = py_s2 - ay25;

	always_ff @(posedge clk) begin
		if (front_en) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
			n_s1  <= n_eff;
			ax_s2 <= prod_x[RECIP_SHIFT +: QUOT_W];
			ay_s2 <= prod_y[RECIP_SHIFT +: QUOT_W];
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			n_s2  <= n_s1;
			qx_s3 <= {ax_s2, GRID_SHIFT'(0)} + COORD_W'(DIV_TAB[rx[REM_W-1:0]]);
			qy_s3 <= {ay_s2, GRID_SHIFT'(0)} + COORD_W'(DIV_TAB[ry[REM_W-1:0]]);
			n_s3  <= n_s2;
		end
	end

	assign item.qx = qx_s3;
	assign item.qy = qy_s3;
	assign item.n  = n_s3;

endmodule

>>> rtl/gnp_queue.sv
// ----------------------------------------------------------------------------
// gnp_queue: small FIFO between the front and back sections
// Lets the front keep taking beats while the back is held by the output.
// ----------------------------------------------------------------------------
module gnp_queue import gnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  coord_item_t wr_item,
	output logic        full,
	input  logic        pop,
	output coord_item_t rd_item,
	output logic        empty
);

	coord_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/gnp_octave.sv
// ----------------------------------------------------------------------------
// gnp_octave: one octave of gradient noise, eight pipeline stages
// Lattice cell and fraction, corner hashes, sine/cosine gradients, corner
// dot products and the smoothstep-weighted bilinear blend.
// ----------------------------------------------------------------------------
module gnp_octave import gnp_pkg::*; #(
	parameter int OCT_IDX = 0
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [COORD_W-1:0]      qx,
	input  logic [COORD_W-1:0]      qy,
	output logic signed [VAL_W-1:0] value
);

	localparam int SHIFT = MAX_OCTAVES - 1 - OCT_IDX;

	logic [UX_W-1:0]       ux, uy;
	logic [COORD_BITS-1:0] x0, y0;
	logic [FRAC_BITS-1:0]  fx, fy;
	logic [14:0]           wx, wy;
	logic [29:0]           wxx, wyy;

	logic [31:0]           hx_s1 [2];
	logic [COORD_BITS-1:0] y_s1 [2];
	logic [FRAC_BITS-1:0]  fx_s1, fy_s1;
	logic [14:0]           wx_s1, wy_s1, w2x_s1, w2y_s1;

	logic [16:0]           fac_x, fac_y;
	logic [31:0]           sxp, syp;
	logic [31:0]           ha_s2 [4];
	logic [31:0]           hb_s2 [4];
	logic [FRAC_BITS-1:0]  fx_s2, fy_s2;
	logic [15:0]           sx_s2, sy_s2;

	logic [SINE_TABLE_BITS-1:0] h_s3 [4];
	logic [FRAC_BITS-1:0]  fx_s3, fy_s3;
	logic [15:0]           sx_s3, sy_s3;

	logic signed [PROD_W-1:0] pa_s4 [4];
	logic signed [PROD_W-1:0] pb_s4 [4];
	logic [15:0]           sx_s4, sy_s4;

	logic signed [VAL_W-1:0] c_s5 [4];
	logic [15:0]           sx_s5, sy_s5;

	logic signed [VAL_W:0]   dt, db;
	logic signed [BL_W-1:0]  mt_s6, mb_s6;
	logic signed [VAL_W-1:0] c0_s6, c2_s6;
	logic [15:0]             sy_s6;

	logic signed [VAL_W-1:0] top, bot, oct_val;
	logic signed [VAL_W:0]   dv;
	logic signed [BL_W-1:0]  m_s7;
	logic signed [VAL_W-1:0] top_s7;
	logic signed [VAL_W-1:0] value_s8;

	// Lattice cell and fraction at this octave's frequency
	assign ux  = UX_W'(qx >> SHIFT);
	assign uy  = UX_W'(qy >> SHIFT);
	assign x0  = ux[FRAC_BITS +: COORD_BITS];
	assign y0  = uy[FRAC_BITS +: COORD_BITS];
	assign fx  = ux[FRAC_BITS-1:0];
	assign fy  = uy[FRAC_BITS-1:0];
	assign wx  = fx[FRAC_BITS-1 -: 15];
	assign wy  = fy[FRAC_BITS-1 -: 15];
	assign wxx = wx * wx;
	assign wyy = wy * wy;

	// Stage 1: first hash multiply per column, weight square
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1[0] <= 32'(x0) * HASH_K1;
			hx_s1[1] <= 32'(COORD_BITS'(x0 + 1'b1)) * HASH_K1;
			y_s1[0]  <= y0;
			y_s1[1]  <= COORD_BITS'(y0 + 1'b1);
			fx_s1    <= fx;
			fy_s1    <= fy;
			wx_s1    <= wx;
			wy_s1    <= wy;
			w2x_s1   <= wxx[29:15];
			w2y_s1   <= wyy[29:15];
		end
	end

	// Stage 2: smoothstep product
	assign fac_x = 17'(3 * Q15_ONE) - {1'b0, wx_s1, 1'b0};
	assign fac_y = 17'(3 * Q15_ONE) - {1'b0, wy_s1, 1'b0};
	assign sxp   = w2x_s1 * fac_x;
	assign syp   = w2y_s1 * fac_y;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			sx_s2 <= sxp[15 +: 16];
			sy_s2 <= syp[15 +: 16];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
		end
	end

	// Corners: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
	for (genvar j = 0; j < 4; j++) begin : g_corner
		localparam int XS = j % 2;
		localparam int YS = j / 2;

		logic [31:0]             hb_c, hc_c;
		logic signed [DXY_W-1:0] dx, dy;
		grad_t                   sn, cs;
		logic signed [PROD_W:0]  csum;

		assign hb_c = (32'(y_s1[YS]) ^ rot_half(hx_s1[XS])) * HASH_K2;
		assign hc_c = (ha_s2[j] ^ rot_half(hb_s2[j])) * HASH_K3;
		assign dx   = $signed({(XS == 1) ? 2'b11 : 2'b00, fx_s3});
		assign dy   = $signed({(YS == 1) ? 2'b11 : 2'b00, fy_s3});
		assign sn   = grad_sine(h_s3[j]);
		assign cs   = grad_sine(h_s3[j] + COS_OFS);
		assign csum = (PROD_W + 1)'(pa_s4[j]) + (PROD_W + 1)'(pb_s4[j]);

		// Hash rounds, gradient products, corner dot product
		always_ff @(posedge clk) begin
			if (en) begin
				ha_s2[j] <= hx_s1[XS];
				hb_s2[j] <= hb_c;
				h_s3[j]  <= hc_c[31 -: SINE_TABLE_BITS];
				pa_s4[j] <= dx * sn;
				pb_s4[j] <= dy * cs;
				c_s5[j]  <= VAL_W'(csum >>> FRAC_BITS);
			end
		end
	end

	// Stage 6: horizontal blend products
	assign dt = (VAL_W + 1)'(c_s5[1]) - (VAL_W + 1)'(c_s5[0]);
	assign db = (VAL_W + 1)'(c_s5[3]) - (VAL_W + 1)'(c_s5[2]);

	// Stage 7: finish rows, vertical blend product
	assign top = c0_s6 + VAL_W'(mt_s6 >>> 15);
	assign bot = c2_s6 + VAL_W'(mb_s6 >>> 15);
	assign dv  = (VAL_W + 1)'(bot) - (VAL_W + 1)'(top);

	// Stage 8: finish and weight the octave
	assign oct_val = top_s7 + VAL_W'(m_s7 >>> 15);

	always_ff @(posedge clk) begin
		if (en) begin
			mt_s6    <= dt * $signed({1'b0, sx_s5});
			mb_s6    <= db * $signed({1'b0, sx_s5});
			c0_s6    <= c_s5[0];
			c2_s6    <= c_s5[2];
			sy_s6    <= sy_s5;
			m_s7     <= dv * $signed({1'b0, sy_s6});
			top_s7   <= top;
			value_s8 <= oct_val >>> OCT_IDX;
		end
	end

	assign value = value_s8;

endmodule

>>> rtl/gnp_back.sv
// ----------------------------------------------------------------------------
// gnp_back: octave pipelines, octave sum, scaling and output register
// Pulls classified beats from the queue, runs all octaves side by side and
// maps the saturated sum to a grey byte.
// ----------------------------------------------------------------------------
module gnp_back import gnp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  coord_item_t       head,
	input  logic              head_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [GREY_W-1:0] grey_level
);

	logic                       back_en;
	logic [BACK_STAGES-1:0]     v_q;
	logic [OCT_W-1:0]           n_q [OCT_STAGES];
	logic                       out_valid_q;
	logic [GREY_W-1:0]          grey_q;
	logic signed [VAL_W-1:0]    oct_value [MAX_OCTAVES];
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [SUM_W-1:0]    sum_s9;
	logic signed [SCL_W-1:0]    prod_s10;
	logic signed [SCL_W-16:0]   scaled;
	logic signed [17:0]         v_sat;
	logic [16:0]                u;
	logic [24:0]                u255;

	// Hold everything while the output beat waits
	assign back_en = !(out_valid_q && out_stall);
	assign pop     = back_en && !head_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			v_q         <= {v_q[BACK_STAGES-2:0], !head_empty};
			out_valid_q <= v_q[BACK_STAGES-1];
		end
	end

	// Carry the octave count alongside the octave stages
	always_ff @(posedge clk) begin
		if (back_en) begin
			n_q[0] <= head.n;
			for (int k = 1; k < OCT_STAGES; k++) begin
				n_q[k] <= n_q[k-1];
			end
		end
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		gnp_octave #(
			.OCT_IDX(i)
		) u_octave (
			.clk   (clk),
			.en    (back_en),
			.qx    (head.qx),
			.qy    (head.qy),
			.value (oct_value[i])
		);
	end

	// Sum the enabled octaves
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (i < 32'(n_q[OCT_STAGES-1])) begin
				sum_c = sum_c + SUM_W'(oct_value[i]);
			end
		end
	end

	// Scale by 1.2, saturate to plus or minus one, map to a byte
	assign scaled = (SCL_W - 15)'(prod_s10 >>> 15);

	always_comb begin
		if (scaled > (SCL_W - 15)'(Q15_ONE)) begin
			v_sat = 18'(Q15_ONE);
		end else if (scaled < -(SCL_W - 15)'(Q15_ONE)) begin
			v_sat = -18'(Q15_ONE);
		end else begin
			v_sat = 18'(scaled);
		end
	end

	assign u    = 17'(v_sat + 18'(Q15_ONE));
	assign u255 = {u, 8'b0} - 25'(u);

	always_ff @(posedge clk) begin
		if (back_en) begin
			sum_s9   <= sum_c;
			prod_s10 <= sum_s9 * SCALE_Q15;
			grey_q   <= u255[16 +: GREY_W];
		end
	end

	assign out_valid  = out_valid_q;
	assign grey_level = grey_q;

endmodule

>>> rtl/gradient_noise_pixel_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_pixel_top: fractal gradient noise, one grey byte per pixel
// Beats pass the front stages, queue, octave stages, sum, scale and output.
// One pixel per cycle unless stalled; all octaves run in parallel pipelines.
// Back pressure fills a four-entry queue before the input stalls.
// Reset clears control state and sets the octave count to 4; no sweep.
// ----------------------------------------------------------------------------
module gradient_noise_pixel_top import gnp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIXEL_W-1:0] pixel_x,
	input  logic [PIXEL_W-1:0] pixel_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [GREY_W-1:0]  grey_level,
	input  logic               cfg_write_en,
	input  logic [CFG_W-1:0]   cfg_write_data
);

	logic        q_push, q_full, q_pop, q_empty;
	coord_item_t q_wr_item, q_rd_item;

	// Accept and scale coordinates
	gnp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.queue_full     (q_full),
		.push           (q_push),
		.item           (q_wr_item)
	);

	// Decouple front and back
	gnp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// Compute noise and drive the output beat
	gnp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd_item),
		.head_empty (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grey_level (grey_level)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue push while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue pop while empty");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full) else $error("input stalled with queue space");
`endif

endmodule
